@@ rtl/lpsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_pkg
// shared types and constants of the length-prefixed size codec
// ----------------------------------------------------------------------------
package lpsc_pkg;

	// widest size payload, in bytes (1 to 8)
	localparam int MAX_SIZE_BYTES = 8;

	localparam logic [7:0] SIZE_THRESHOLD = 8'd248;
	localparam logic [7:0] HEADER_BASE    = 8'd247;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [63:0] size_value;
		logic [7:0]  code_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic [63:0] decoded_value;
		logic [3:0]  bytes_used;
	} out_item_t;

	// classified work handed from front to back
	// encode: value is the (saturated) size, count is payload bytes, 0 = single byte
	// decode: value is the decoded size, count is bytes used
	typedef struct packed {
		logic        is_decode;
		logic [63:0] value;
		logic [3:0]  count;
	} job_t;

endpackage
`default_nettype wire

@@ rtl/lpsc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_front
// accepts input items, sizes encode values and runs the decode collector
// ----------------------------------------------------------------------------
module lpsc_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    mode,
	input  wire                    clear,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  lpsc_pkg::in_item_t     in_data,
	input  wire                    job_full,
	output logic                   job_push,
	output lpsc_pkg::job_t         job_data
);
	import lpsc_pkg::*;

	logic [3:0]  rem_q;
	logic [3:0]  pos_q;
	logic [63:0] acc_q;

	logic        accept;
	logic        over;
	logic [63:0] sat_v;
	logic [3:0]  nbytes;
	logic [3:0]  rem_d;
	logic [3:0]  pos_d;
	logic [63:0] acc_d;
	logic        dec_done;
	logic [63:0] dec_value;
	logic [3:0]  dec_used;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;

	// saturate and count significant bytes
	always_comb begin
		over   = 1'b0;
		sat_v  = '0;
		nbytes = '0;
		for (int i = 0; i < 8; i++) begin
			if (i >= MAX_SIZE_BYTES) begin
				over = over | (|in_data.size_value[8*i +: 8]);
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (i < MAX_SIZE_BYTES) begin
				sat_v[8*i +: 8] = over ? 8'hFF : in_data.size_value[8*i +: 8];
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (|sat_v[8*i +: 8]) begin
				nbytes = 4'(i + 1);
			end
		end
		if (sat_v < {56'd0, SIZE_THRESHOLD}) begin
			nbytes = '0;
		end
	end

	// decode collector
	always_comb begin
		rem_d     = rem_q;
		pos_d     = pos_q;
		acc_d     = acc_q;
		dec_done  = 1'b0;
		dec_value = '0;
		dec_used  = '0;
		if (rem_q == 4'd0) begin
			if (in_data.code_byte < SIZE_THRESHOLD) begin
				dec_done  = 1'b1;
				dec_value = {56'd0, in_data.code_byte};
				dec_used  = 4'd1;
			end else begin
				rem_d = 4'(in_data.code_byte - HEADER_BASE);
				pos_d = '0;
				acc_d = '0;
			end
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (i < MAX_SIZE_BYTES && pos_q == 4'(i)) begin
					acc_d[8*i +: 8] = acc_q[8*i +: 8] | in_data.code_byte;
				end
			end
			pos_d = pos_q + 4'd1;
			rem_d = rem_q - 4'd1;
			if (rem_d == 4'd0) begin
				dec_done  = 1'b1;
				dec_value = acc_d;
				dec_used  = pos_d + 4'd1;
				acc_d     = '0;
				pos_d     = '0;
			end
		end
	end

	always_comb begin
		job_push = 1'b0;
		job_data = '0;
		if (mode == MODE_ENCODE) begin
			job_push           = accept;
			job_data.is_decode = 1'b0;
			job_data.value     = sat_v;
			job_data.count     = nbytes;
		end else begin
			job_push           = accept && dec_done;
			job_data.is_decode = 1'b1;
			job_data.value     = dec_value;
			job_data.count     = dec_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			pos_q <= '0;
			acc_q <= '0;
		end else if (clear) begin
			rem_q <= '0;
			pos_q <= '0;
			acc_q <= '0;
		end else if (accept && mode == MODE_DECODE) begin
			rem_q <= rem_d;
			pos_q <= pos_d;
			acc_q <= acc_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/lpsc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module lpsc_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  lpsc_pkg::job_t  push_data,
	output logic            full,
	input  wire             pop,
	output logic            not_empty,
	output lpsc_pkg::job_t  pop_data
);
	import lpsc_pkg::*;

	job_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/lpsc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_back
// turns jobs into results, one byte a cycle for encoded runs while not stalled
// ----------------------------------------------------------------------------
module lpsc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  job_valid,
	input  lpsc_pkg::job_t       job_data,
	output logic                 job_pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output lpsc_pkg::out_item_t  out_data
);
	import lpsc_pkg::*;

	logic        busy_q;
	logic [63:0] shift_q;
	logic [3:0]  left_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        load;
	out_item_t   next_item;

	assign load      = !out_valid_q || out_ready;
	assign job_pop   = load && !busy_q && job_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		next_item = '0;
		if (busy_q) begin
			next_item.out_byte = shift_q[7:0];
			next_item.out_last = (left_q == 4'd1);
		end else if (job_data.is_decode) begin
			next_item.out_last      = 1'b1;
			next_item.decoded_value = job_data.value;
			next_item.bytes_used    = job_data.count;
		end else if (job_data.count == 4'd0) begin
			next_item.out_byte = job_data.value[7:0];
			next_item.out_last = 1'b1;
		end else begin
			next_item.out_byte = HEADER_BASE + {4'd0, job_data.count};
			next_item.out_last = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && (busy_q || job_valid)) begin
			out_q <= next_item;
		end
		if (load && busy_q) begin
			shift_q <= {8'd0, shift_q[63:8]};
		end else if (job_pop) begin
			shift_q <= job_data.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= busy_q || job_valid;
			if (busy_q) begin
				left_q <= left_q - 4'd1;
				busy_q <= (left_q != 4'd1);
			end else if (job_valid && !job_data.is_decode && job_data.count != 4'd0) begin
				left_q <= job_data.count;
				busy_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/length_prefixed_size_codec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_size_codec
// encodes 64-bit sizes into length-prefixed little-endian bytes, or decodes
// such bytes back into sizes, selected by the codec_mode register
// ----------------------------------------------------------------------------
//
//  channel   signals                         moves
//  -------   -----------------------------   --------------------------------
//  cfg       cfg_we, cfg_wdata               codec_mode write, no wait
//  in        in_valid, in_ready, in_data     one size or one code byte
//  out       out_valid, out_ready, out_data  one code byte or one decoded size
//
//  encode: a size below 248 gives one code byte, else a header byte and 1 to
//  8 payload bytes, one byte a cycle out of the back-end serializer while out
//  is not stalled; decode takes a byte a cycle while the job queue is not full
//  first result is registered in the job queue, then in the serializer output
//  register, before it can transfer; reset clears the mode (encode), the decode
//  progress and the job queue; input and output stall on their own: the
//  two-entry job queue decouples the front from the serializer, and in_ready
//  drops only when it is full
module length_prefixed_size_codec (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire                  cfg_wdata,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  lpsc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output lpsc_pkg::out_item_t  out_data
);
	import lpsc_pkg::*;

	// mode register, any write also restarts the decode collector
	logic codec_mode_q;

	// front to queue
	logic job_full;
	logic job_push;
	job_t job_in;

	// queue to back
	logic job_valid;
	logic job_pop;
	job_t job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= MODE_ENCODE;
		end else if (cfg_we) begin
			codec_mode_q <= cfg_wdata;
		end
	end

	// classifies each input transfer: sizes get their byte count here,
	// code bytes are collected until a size is complete
	lpsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (codec_mode_q),
		.clear    (cfg_we),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.job_full (job_full),
		.job_push (job_push),
		.job_data (job_in)
	);

	// short job queue so that the front keeps taking input while the
	// serializer is still sending a long run
	lpsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.not_empty (job_valid),
		.pop_data  (job_out)
	);

	// serializer with registered output transfer
	lpsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_out),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
